/* rtl/pid_controller_with_limits_core_assert.svh */
// assertion macros for the pid controller checker
// no dependencies; taken in by `include
`ifndef PID_CONTROLLER_WITH_LIMITS_CORE_ASSERT_SVH
`define PID_CONTROLLER_WITH_LIMITS_CORE_ASSERT_SVH

// implication checked at every rising edge outside reset
`define PIDL_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define PIDL_ASSERT_NEXT(lbl, ck, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pidl_pkg.sv */
// shared types, constants and saturation helpers for the pid controller
// no dependencies
package pidl_pkg;

	localparam int DATA_W    = 32;
	localparam int INTEG_W   = 48;
	localparam int ACC_W     = 62;
	localparam int FRAC_BITS = 16;
	localparam int PER_W     = 16;
	localparam int TICKS     = 1000;
	localparam int WIDE_W    = 66;
	localparam int A_W       = INTEG_W;
	localparam int B_W       = 32;
	localparam int PROD_W    = A_W + B_W;
	localparam int DIGIT_W   = 8;
	localparam int MUL_STEPS = B_W / DIGIT_W;
	localparam int DIV_BITS  = 2;
	localparam int DIV_STEPS = A_W / DIV_BITS;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 5;
	localparam int EN_W      = 2;

	localparam logic signed [WIDE_W-1:0] DATA_HI =
		{{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] DATA_LO = ~DATA_HI;
	localparam logic signed [WIDE_W-1:0] INTEG_HI =
		{{(WIDE_W-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] INTEG_LO = ~INTEG_HI;
	localparam logic signed [WIDE_W-1:0] ACC_HI =
		{{(WIDE_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
	localparam logic signed [WIDE_W-1:0] ACC_LO = ~ACC_HI;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ERR, ST_LOAD, ST_MUL, ST_DIV, ST_WB, ST_CLAMP, ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_INC, OP_DER, OP_P, OP_I, OP_D, OP_RATE, OP_LIM
	} op_t;

	typedef enum logic [2:0] {
		REG_KP, REG_KI, REG_KD, REG_OUT_MAX, REG_OUT_MIN, REG_RATE_MAX, REG_RATE_MIN,
		REG_ENABLES
	} reg_idx_t;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [WIDE_W-1:0] v);
		if (v > DATA_HI) return DATA_HI[DATA_W-1:0];
		else if (v < DATA_LO) return DATA_LO[DATA_W-1:0];
		else return v[DATA_W-1:0];
	endfunction

	function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [WIDE_W-1:0] v);
		if (v > INTEG_HI) return INTEG_HI[INTEG_W-1:0];
		else if (v < INTEG_LO) return INTEG_LO[INTEG_W-1:0];
		else return v[INTEG_W-1:0];
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		if (v > ACC_HI) return ACC_HI[ACC_W-1:0];
		else if (v < ACC_LO) return ACC_LO[ACC_W-1:0];
		else return v[ACC_W-1:0];
	endfunction

	function automatic logic [WIDE_W-1:0] mag(input logic signed [WIDE_W-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

endpackage

/* rtl/pidl_if.sv */
// request channels of the pid controller: measurement in, drive out
// depends on pidl_pkg
interface pidl_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [pidl_pkg::DATA_W-1:0] measured;
	logic signed [pidl_pkg::DATA_W-1:0] setpoint;
	logic [pidl_pkg::PER_W-1:0] period_ms;
	modport source(output valid, kind, measured, setpoint, period_ms, input ready);
	modport sink(input valid, kind, measured, setpoint, period_ms, output ready);
endinterface

interface pidl_out_if;
	logic valid;
	logic ready;
	logic signed [pidl_pkg::DATA_W-1:0] drive;
	logic signed [pidl_pkg::DATA_W-1:0] raw_drive;
	modport source(output valid, drive, raw_drive, input ready);
	modport sink(input valid, drive, raw_drive, output ready);
endinterface

/* rtl/pid_controller_with_limits_core.sv */
// pid controller with output clamp and slew limit, signed q16.16
// depends on pidl_pkg and the channel interfaces in pidl_if.sv
//
//  channel  | dir | payload                                  | accepted when
//  in_ch    | in  | kind, measured, setpoint, period_ms      | valid && ready
//  out_ch   | out | drive, raw_drive                         | valid && ready
//  apb      | in  | paddr, pwdata (8 registers at 4*index)   | psel && penable && pwrite
//
// one request at a time: an update forms the error, then runs increment, derivative and
// the P, I and D terms, the clamp, the rate check with the rate limiter on and the limit
// step when it limits, on the shared 48x8 multiplier and the 2 bit a cycle divider,
// used for up to seven operations; a clear request goes straight to the done state
// in_ch.ready is high only when the sequencer is idle; a finished result waits in
// the done state while a previous result is still held in the output register
// reset clears the state, the registers to their defaults and the output valid
module pid_controller_with_limits_core (
	input  logic clk,
	input  logic arst_n,
	pidl_in_if.sink in_ch,
	pidl_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pidl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int DW = pidl_pkg::DATA_W;
	localparam int WW = pidl_pkg::WIDE_W;

	// configuration registers
	logic signed [DW-1:0] kp_q, ki_q, kd_q, out_max_q, out_min_q, rate_max_q, rate_min_q;
	logic [pidl_pkg::EN_W-1:0] en_q;

	// sequencer
	pidl_pkg::state_t state_q, state_d;
	pidl_pkg::op_t op_q, op_d;
	logic [pidl_pkg::CNT_W-1:0] cnt_q;

	// controller state and per-request values
	logic signed [pidl_pkg::INTEG_W-1:0] integ_q;
	logic signed [DW-1:0] perr_q, pdrv_q;
	logic signed [DW-1:0] meas_q, sp_q, e_q, der_q, raw_q, drv_q, lim_q;
	logic [pidl_pkg::PER_W-1:0] per_q;
	logic signed [WW-1:0] sum_q;

	// shared multiply / divide unit
	logic [pidl_pkg::PROD_W-1:0] a_q, prod_q, prod_d;
	logic [pidl_pkg::B_W-1:0] b_q;
	logic neg_q;
	logic [pidl_pkg::A_W-1:0] dq_q, dq_d;
	logic [pidl_pkg::PER_W-1:0] rem_q, rem_d, dvsr_q;

	// output register
	logic out_valid_q;
	logic signed [DW-1:0] out_drive_q, out_raw_q;

	// combinational helpers
	logic in_acc, out_free, wr_en, gain_op, mul_last, div_last;
	logic rate_hi, rate_lo;
	logic signed [WW-1:0] opa, opb, res;
	logic [WW-1:0] mag_a, mag_b;
	logic [pidl_pkg::PROD_W-pidl_pkg::FRAC_BITS-1:0] mag_res;
	logic [pidl_pkg::PER_W:0] rem_t;
	logic [pidl_pkg::PER_W-1:0] dvsr_sel;
	logic signed [DW-1:0] raw_c, clamp_c;

	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign wr_en    = psel && penable && pwrite;
	assign in_ch.ready = (state_q == pidl_pkg::ST_IDLE);
	assign pready   = 1'b1;

	assign out_ch.valid     = out_valid_q;
	assign out_ch.drive     = out_drive_q;
	assign out_ch.raw_drive = out_raw_q;

	// gain products drop the fraction and skip the divider
	assign gain_op  = (op_q == pidl_pkg::OP_P) || (op_q == pidl_pkg::OP_I) ||
		(op_q == pidl_pkg::OP_D);
	assign mul_last = (cnt_q == pidl_pkg::CNT_W'(pidl_pkg::MUL_STEPS - 1));
	assign div_last = (cnt_q == pidl_pkg::CNT_W'(pidl_pkg::DIV_STEPS - 1));

	// operand select for the shared unit
	always_comb begin
		opa = '0;
		opb = '0;
		dvsr_sel = per_q;
		unique case (op_q)
			pidl_pkg::OP_INC: begin
				opa = WW'(e_q);
				opb = WW'({1'b0, per_q});
				dvsr_sel = pidl_pkg::PER_W'(pidl_pkg::TICKS);
			end
			pidl_pkg::OP_DER: begin
				opa = WW'(e_q) - WW'(perr_q);
				opb = WW'(pidl_pkg::TICKS);
			end
			pidl_pkg::OP_P: begin
				opa = WW'(e_q);
				opb = WW'(kp_q);
			end
			pidl_pkg::OP_I: begin
				opa = WW'(integ_q);
				opb = WW'(ki_q);
			end
			pidl_pkg::OP_D: begin
				opa = WW'(der_q);
				opb = WW'(kd_q);
			end
			pidl_pkg::OP_RATE: begin
				opa = WW'(drv_q) - WW'(pdrv_q);
				opb = WW'(pidl_pkg::TICKS);
			end
			pidl_pkg::OP_LIM: begin
				opa = WW'(lim_q);
				opb = WW'({1'b0, per_q});
				dvsr_sel = pidl_pkg::PER_W'(pidl_pkg::TICKS);
			end
			default: begin
				opa = '0;
			end
		endcase
		mag_a = pidl_pkg::mag(opa);
		mag_b = pidl_pkg::mag(opb);
	end

	// one multiplier digit and two divider bits a cycle
	always_comb begin
		prod_d = prod_q + pidl_pkg::PROD_W'(a_q * b_q[pidl_pkg::DIGIT_W-1:0]);
		dq_d   = dq_q;
		rem_d  = rem_q;
		for (int i = 0; i < pidl_pkg::DIV_BITS; i++) begin
			rem_t = {rem_d, dq_d[pidl_pkg::A_W-1]};
			dq_d  = dq_d << 1;
			if (rem_t >= {1'b0, dvsr_q}) begin
				rem_t = rem_t - {1'b0, dvsr_q};
				dq_d[0] = 1'b1;
			end
			rem_d = rem_t[pidl_pkg::PER_W-1:0];
		end
	end

	// signed result of the finished operation
	always_comb begin
		if (gain_op) mag_res = prod_q[pidl_pkg::PROD_W-1:pidl_pkg::FRAC_BITS];
		else mag_res = {{(pidl_pkg::PROD_W-pidl_pkg::FRAC_BITS-pidl_pkg::A_W){1'b0}}, dq_q};
		res = neg_q ? -WW'(mag_res) : WW'(mag_res);
		rate_hi = res > WW'(rate_max_q);
		rate_lo = res < WW'(rate_min_q);
	end

	// value clamp, out_max tested first
	always_comb begin
		raw_c = pidl_pkg::sat_data(sum_q);
		clamp_c = raw_c;
		if (en_q[0]) begin
			priority if (raw_c > out_max_q) clamp_c = out_max_q;
			else if (raw_c < out_min_q) clamp_c = out_min_q;
			else clamp_c = raw_c;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		unique case (state_q)
			pidl_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (in_ch.kind == pidl_pkg::KIND_CLEAR) state_d = pidl_pkg::ST_DONE;
					else state_d = pidl_pkg::ST_ERR;
				end
			end
			pidl_pkg::ST_ERR: begin
				op_d = pidl_pkg::OP_INC;
				state_d = pidl_pkg::ST_LOAD;
			end
			pidl_pkg::ST_LOAD: state_d = pidl_pkg::ST_MUL;
			pidl_pkg::ST_MUL: begin
				if (mul_last) state_d = gain_op ? pidl_pkg::ST_WB : pidl_pkg::ST_DIV;
			end
			pidl_pkg::ST_DIV: begin
				if (div_last) state_d = pidl_pkg::ST_WB;
			end
			pidl_pkg::ST_WB: begin
				unique case (op_q)
					pidl_pkg::OP_INC: begin
						op_d = pidl_pkg::OP_DER;
						state_d = pidl_pkg::ST_LOAD;
					end
					pidl_pkg::OP_DER: begin
						op_d = pidl_pkg::OP_P;
						state_d = pidl_pkg::ST_LOAD;
					end
					pidl_pkg::OP_P: begin
						op_d = pidl_pkg::OP_I;
						state_d = pidl_pkg::ST_LOAD;
					end
					pidl_pkg::OP_I: begin
						op_d = pidl_pkg::OP_D;
						state_d = pidl_pkg::ST_LOAD;
					end
					pidl_pkg::OP_D: state_d = pidl_pkg::ST_CLAMP;
					pidl_pkg::OP_RATE: begin
						if (rate_hi || rate_lo) begin
							op_d = pidl_pkg::OP_LIM;
							state_d = pidl_pkg::ST_LOAD;
						end else begin
							state_d = pidl_pkg::ST_DONE;
						end
					end
					pidl_pkg::OP_LIM: state_d = pidl_pkg::ST_DONE;
					default: state_d = pidl_pkg::ST_DONE;
				endcase
			end
			pidl_pkg::ST_CLAMP: begin
				if (en_q[1]) begin
					op_d = pidl_pkg::OP_RATE;
					state_d = pidl_pkg::ST_LOAD;
				end else begin
					state_d = pidl_pkg::ST_DONE;
				end
			end
			pidl_pkg::ST_DONE: begin
				if (out_free) state_d = pidl_pkg::ST_IDLE;
			end
			default: state_d = pidl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pidl_pkg::ST_IDLE;
			op_q <= pidl_pkg::OP_INC;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0;
			ki_q <= '0;
			kd_q <= '0;
			out_max_q <= pidl_pkg::DATA_HI[DW-1:0];
			out_min_q <= pidl_pkg::DATA_LO[DW-1:0];
			rate_max_q <= pidl_pkg::DATA_HI[DW-1:0];
			rate_min_q <= pidl_pkg::DATA_LO[DW-1:0];
			en_q <= '0;
		end else if (wr_en) begin
			unique case (pidl_pkg::reg_idx_t'(paddr[4:2]))
				pidl_pkg::REG_KP:       kp_q <= pwdata;
				pidl_pkg::REG_KI:       ki_q <= pwdata;
				pidl_pkg::REG_KD:       kd_q <= pwdata;
				pidl_pkg::REG_OUT_MAX:  out_max_q <= pwdata;
				pidl_pkg::REG_OUT_MIN:  out_min_q <= pwdata;
				pidl_pkg::REG_RATE_MAX: rate_max_q <= pwdata;
				pidl_pkg::REG_RATE_MIN: rate_min_q <= pwdata;
				pidl_pkg::REG_ENABLES:  en_q <= pwdata[pidl_pkg::EN_W-1:0];
				default: en_q <= en_q;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (pidl_pkg::reg_idx_t'(paddr[4:2]))
			pidl_pkg::REG_KP:       prdata = kp_q;
			pidl_pkg::REG_KI:       prdata = ki_q;
			pidl_pkg::REG_KD:       prdata = kd_q;
			pidl_pkg::REG_OUT_MAX:  prdata = out_max_q;
			pidl_pkg::REG_OUT_MIN:  prdata = out_min_q;
			pidl_pkg::REG_RATE_MAX: prdata = rate_max_q;
			pidl_pkg::REG_RATE_MIN: prdata = rate_min_q;
			pidl_pkg::REG_ENABLES:  prdata = 32'(en_q);
			default: prdata = '0;
		endcase
	end

	// controller state: integral, previous error, previous drive and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			perr_q <= '0;
			pdrv_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pidl_pkg::ST_IDLE && in_acc && in_ch.kind == pidl_pkg::KIND_CLEAR)
				integ_q <= '0;
			if (state_q == pidl_pkg::ST_WB && op_q == pidl_pkg::OP_INC)
				integ_q <= pidl_pkg::sat_integ(WW'(integ_q) + res);
			if (state_q == pidl_pkg::ST_DONE && out_free) begin
				perr_q <= e_q;
				pdrv_q <= drv_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			pidl_pkg::ST_IDLE: begin
				meas_q <= in_ch.measured;
				sp_q <= in_ch.setpoint;
				// a zero period counts as one millisecond
				per_q <= (in_ch.period_ms == '0) ? pidl_pkg::PER_W'(1) : in_ch.period_ms;
				// a clear request leaves zeros to be stored and shown
				e_q <= '0;
				drv_q <= '0;
				raw_q <= '0;
			end
			pidl_pkg::ST_ERR: e_q <= pidl_pkg::sat_data(WW'(sp_q) - WW'(meas_q));
			pidl_pkg::ST_LOAD: begin
				a_q <= pidl_pkg::PROD_W'(mag_a[pidl_pkg::A_W-1:0]);
				b_q <= mag_b[pidl_pkg::B_W-1:0];
				neg_q <= (opa < 0) != (opb < 0);
				prod_q <= '0;
				dvsr_q <= dvsr_sel;
				cnt_q <= '0;
			end
			pidl_pkg::ST_MUL: begin
				prod_q <= prod_d;
				a_q <= a_q << pidl_pkg::DIGIT_W;
				b_q <= b_q >> pidl_pkg::DIGIT_W;
				// products that reach the divider stay within the dividend width
				dq_q <= prod_d[pidl_pkg::A_W-1:0];
				rem_q <= '0;
				cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
			end
			pidl_pkg::ST_DIV: begin
				dq_q <= dq_d;
				rem_q <= rem_d;
				cnt_q <= cnt_q + 1'b1;
			end
			pidl_pkg::ST_WB: begin
				unique case (op_q)
					pidl_pkg::OP_DER: der_q <= pidl_pkg::sat_data(res);
					pidl_pkg::OP_P: sum_q <= WW'(pidl_pkg::sat_acc(res));
					pidl_pkg::OP_I, pidl_pkg::OP_D:
						sum_q <= sum_q + WW'(pidl_pkg::sat_acc(res));
					// rate_max is tested before rate_min
					pidl_pkg::OP_RATE: lim_q <= rate_hi ? rate_max_q : rate_min_q;
					pidl_pkg::OP_LIM: drv_q <= pidl_pkg::sat_data(WW'(pdrv_q) + res);
					default: der_q <= der_q;
				endcase
			end
			pidl_pkg::ST_CLAMP: begin
				raw_q <= raw_c;
				drv_q <= clamp_c;
			end
			pidl_pkg::ST_DONE: begin
				if (out_free) begin
					out_drive_q <= drv_q;
					out_raw_q <= raw_q;
				end
			end
			default: cnt_q <= '0;
		endcase
	end

endmodule

/* rtl/pidl_checker.sv */
// port-level assertions for the pid controller, bound to the top level
// depends on pid_controller_with_limits_core_assert.svh
`include "pid_controller_with_limits_core_assert.svh"

module pidl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] drive,
	input logic [31:0] raw_drive,
	input logic pready
);

	// one request at a time: busy right after a request is taken
	`PIDL_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")

	// the apb port never waits
	`PIDL_ASSERT_IMP(a_pready_high, clk, arst_n, 1'b1, pready, "pready low")

	// a stalled result stays offered and unchanged
	`PIDL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "valid dropped")
	`PIDL_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(drive) && $stable(raw_drive), "payload moved")

endmodule

bind pid_controller_with_limits_core pidl_checker u_pidl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.drive(out_ch.drive),
	.raw_drive(out_ch.raw_drive),
	.pready(pready)
);

/* sim/pidl_checker.sv */
// watches the request channels and the register port of the pid controller,
// predicts drive and raw_drive for each accepted request and compares them
// depends on pidl_pkg and the channel interfaces in pidl_if.sv
module pidl_scoreboard (
	input  logic clk,
	input  logic arst_n,
	pidl_in_if in_ch,
	pidl_out_if out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [pidl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output int fails,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [pidl_pkg::DATA_W-1:0] drive;
		logic signed [pidl_pkg::DATA_W-1:0] raw_drive;
	} drive_pair_t;

	drive_pair_t drive_q[$];
	logic signed [31:0] gain_p, gain_i, gain_d, clamp_hi, clamp_lo, slew_hi, slew_lo;
	logic [pidl_pkg::EN_W-1:0] limit_en;
	longint integ_acc, last_err, last_drive;

	assign pending = drive_q.size();

	function automatic longint clip(longint v, int w);
		longint hi;
		longint lo;
		if (w >= 64) return v;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// exact product, shift and quotient on magnitudes, truncated, saturated to w bits
	function automatic longint scale_div(longint a, longint b, int sh,
			longint unsigned dv, int w);
		logic [127:0] x;
		logic [127:0] y;
		logic [127:0] p;
		logic [127:0] maxpos;
		logic neg;
		logic [63:0] r;
		neg = (a < 0) != (b < 0);
		x = {64'd0, (a < 0) ? (64'd0 - 64'(a)) : 64'(a)};
		y = {64'd0, (b < 0) ? (64'd0 - 64'(b)) : 64'(b)};
		p = (x * y) >> sh;
		if (dv == 0 || dv > 64'hFFFF_FFFF) dv = 1;
		p = p / {64'd0, dv};
		maxpos = (w >= 64) ? 128'h7FFF_FFFF_FFFF_FFFF : ((128'd1 << (w - 1)) - 1);
		if (neg) begin
			if (p > maxpos + 1) p = maxpos + 1;
			r = 64'd0 - p[63:0];
		end else begin
			if (p > maxpos) p = maxpos;
			r = p[63:0];
		end
		return longint'(r);
	endfunction

	function automatic drive_pair_t control_step(logic kind, longint meas, longint sp,
			logic [pidl_pkg::PER_W-1:0] period);
		drive_pair_t res;
		longint per, err, inc, der, raw, drv, rate;
		if (kind == pidl_pkg::KIND_CLEAR) begin
			integ_acc = 0;
			last_err = 0;
			last_drive = 0;
			res = '0;
			return res;
		end
		per = (period == 0) ? 1 : longint'(period);
		err = clip(sp - meas, pidl_pkg::DATA_W);
		inc = scale_div(err, per, 0, pidl_pkg::TICKS, 64);
		integ_acc = clip(integ_acc + inc, pidl_pkg::INTEG_W);
		der = scale_div(err - last_err, pidl_pkg::TICKS, 0, per, pidl_pkg::DATA_W);
		raw = clip(scale_div(gain_p, err, pidl_pkg::FRAC_BITS, 1, pidl_pkg::ACC_W)
			+ scale_div(gain_i, integ_acc, pidl_pkg::FRAC_BITS, 1, pidl_pkg::ACC_W)
			+ scale_div(gain_d, der, pidl_pkg::FRAC_BITS, 1, pidl_pkg::ACC_W),
			pidl_pkg::DATA_W);
		drv = raw;
		if (limit_en[0]) begin
			if (drv > clamp_hi) drv = clamp_hi;
			else if (drv < clamp_lo) drv = clamp_lo;
		end
		if (limit_en[1]) begin
			rate = scale_div(drv - last_drive, pidl_pkg::TICKS, 0, per, pidl_pkg::ACC_W);
			if (rate > slew_hi)
				drv = clip(last_drive + scale_div(slew_hi, per, 0, pidl_pkg::TICKS, 64),
					pidl_pkg::DATA_W);
			else if (rate < slew_lo)
				drv = clip(last_drive + scale_div(slew_lo, per, 0, pidl_pkg::TICKS, 64),
					pidl_pkg::DATA_W);
		end
		last_drive = drv;
		last_err = err;
		res.drive = drv[pidl_pkg::DATA_W-1:0];
		res.raw_drive = raw[pidl_pkg::DATA_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_pair_t got, want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			gain_p <= 0; gain_i <= 0; gain_d <= 0;
			clamp_hi <= 32'h7FFF_FFFF; clamp_lo <= 32'h8000_0000;
			slew_hi <= 32'h7FFF_FFFF; slew_lo <= 32'h8000_0000;
			limit_en <= 0;
			integ_acc = 0; last_err = 0; last_drive = 0;
			fails <= 0;
			drive_q.delete();
		end else begin
			// register writes land at the access edge
			if (psel && penable && pwrite && pready) begin
				case (pidl_pkg::reg_idx_t'(paddr[pidl_pkg::ADDR_W-1:2]))
					pidl_pkg::REG_KP: gain_p <= pwdata;
					pidl_pkg::REG_KI: gain_i <= pwdata;
					pidl_pkg::REG_KD: gain_d <= pwdata;
					pidl_pkg::REG_OUT_MAX: clamp_hi <= pwdata;
					pidl_pkg::REG_OUT_MIN: clamp_lo <= pwdata;
					pidl_pkg::REG_RATE_MAX: slew_hi <= pwdata;
					pidl_pkg::REG_RATE_MIN: slew_lo <= pwdata;
					pidl_pkg::REG_ENABLES: limit_en <= pwdata[pidl_pkg::EN_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got.drive = out_ch.drive;
				got.raw_drive = out_ch.raw_drive;
				if (drive_q.size() == 0) begin
					$display("%0t unexpected result drive %h raw %h", $time,
						got.drive, got.raw_drive);
					bad++;
				end else begin
					want = drive_q.pop_front();
					if (got.drive !== want.drive) begin
						$display("%0t drive mismatch expected %h actual %h", $time,
							want.drive, got.drive);
						bad++;
					end
					if (got.raw_drive !== want.raw_drive) begin
						$display("%0t raw_drive mismatch expected %h actual %h", $time,
							want.raw_drive, got.raw_drive);
						bad++;
					end
				end
			end
			if (bad != 0) fails <= fails + bad;
			if (in_ch.valid && in_ch.ready)
				drive_q.push_back(control_step(in_ch.kind, longint'(in_ch.measured),
					longint'(in_ch.setpoint), in_ch.period_ms));
		end
	end
endmodule

/* sim/testbench.sv */
// top of the pid controller testbench: clock, reset, register setup,
// request stimulus, output backpressure and the verdict
// depends on pidl_pkg, pidl_if.sv, the core and sim/pidl_checker.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [pidl_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fails;
	int pending;

	// calm: no idling on either side; hold_req bumps ask the receiver for a long hold
	logic calm = 1'b0;
	int hold_req = 0;

	pidl_in_if in_ch();
	pidl_out_if out_ch();

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = pidl_pkg::KIND_UPDATE;
		in_ch.measured = '0;
		in_ch.setpoint = '0;
		in_ch.period_ms = 16'd1;
		out_ch.ready = 1'b0;
	end

	pid_controller_with_limits_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pidl_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold whenever one is requested
	always @(posedge clk) begin
		int hold_seen;
		int hold_left;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	// apb write: setup cycle, then access cycle
	task automatic reg_write(pidl_pkg::reg_idx_t idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= pidl_pkg::ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_limits(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
			logic [31:0] omax, logic [31:0] omin, logic [31:0] rmax, logic [31:0] rmin,
			logic [1:0] en);
		reg_write(pidl_pkg::REG_KP, kp);
		reg_write(pidl_pkg::REG_KI, ki);
		reg_write(pidl_pkg::REG_KD, kd);
		reg_write(pidl_pkg::REG_OUT_MAX, omax);
		reg_write(pidl_pkg::REG_OUT_MIN, omin);
		reg_write(pidl_pkg::REG_RATE_MAX, rmax);
		reg_write(pidl_pkg::REG_RATE_MIN, rmin);
		reg_write(pidl_pkg::REG_ENABLES, {30'd0, en});
	endtask

	// stop offering, wait until every expected result is back, then let the sequencer settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// offer one request, idling first at random, and wait for it to be taken
	task automatic send(logic kind, logic [31:0] meas, logic [31:0] sp, logic [15:0] per);
		while (!calm && $urandom_range(0, 99) < 34) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.measured <= meas;
		in_ch.setpoint <= sp;
		in_ch.period_ms <= per;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			3: return 32'(signed'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
			default: return $urandom;
		endcase
	endfunction

	// gains mostly within +-4.0 so the sum is not always saturated
	function automatic logic [31:0] pick_gain();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
	endfunction

	function automatic logic [15:0] pick_period();
		case ($urandom_range(0, 9))
			0: return 16'd1;
			1: return 16'hFFFF;
			2: return ($urandom_range(0, 19) == 0) ? 16'd0 : 16'd1000;
			3, 4: return 16'($urandom);
			default: return 16'($urandom_range(1, 100));
		endcase
	endfunction

	task automatic random_run(int count);
		logic [31:0] sp;
		sp = pick_value();
		repeat (count) begin
			// a clear now and then; the setpoint mostly holds steady as in a real loop
			if ($urandom_range(0, 29) == 0) begin
				send(pidl_pkg::KIND_CLEAR, $urandom, $urandom, 16'($urandom));
			end else begin
				if ($urandom_range(0, 9) == 0) sp = pick_value();
				send(pidl_pkg::KIND_UPDATE, pick_value(), sp, pick_period());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes of the fields, clear, zero and extreme periods
		load_limits(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 2'd0);
		send(pidl_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0001_0000, 16'd10);
		send(pidl_pkg::KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
		send(pidl_pkg::KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send(pidl_pkg::KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
		send(pidl_pkg::KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
		send(pidl_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send(pidl_pkg::KIND_UPDATE, 32'h0001_0000, 32'h0000_0000, 16'd1000);
		drain();
		// crossed clamp and rate limits, both stages on, full-scale gains
		load_limits(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 2'd3);
		send(pidl_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0010_0000, 16'd5);
		send(pidl_pkg::KIND_UPDATE, 32'h0010_0000, 32'h0000_0000, 16'd5);
		send(pidl_pkg::KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
		send(pidl_pkg::KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
		drain();
		// narrow clamp and slow slew
		load_limits(32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 32'h0005_0000,
			32'hFFFB_0000, 32'h0001_0000, 32'hFFFF_0000, 2'd3);
		send(pidl_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0100_0000, 16'd1);
		send(pidl_pkg::KIND_UPDATE, 32'h0000_0000, 32'h0100_0000, 16'd100);
		send(pidl_pkg::KIND_UPDATE, 32'h0100_0000, 32'h0000_0000, 16'hFFFF);
		send(pidl_pkg::KIND_UPDATE, 32'h0100_0000, 32'h0000_0000, 16'd1);
		send(pidl_pkg::KIND_CLEAR, 32'h0, 32'h0, 16'd0);
		send(pidl_pkg::KIND_UPDATE, 32'hFFFF_0000, 32'h0001_0000, 16'd20);
		drain();

		// random phases, each under new register settings
		for (int phase = 0; phase < 9; phase++) begin
			logic [31:0] a;
			logic [31:0] b;
			a = pick_value();
			b = pick_value();
			if (phase == 8)
				load_limits(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 2'd3);
			else
				load_limits(pick_gain(), pick_gain(), pick_gain(),
					($signed(a) > $signed(b) || phase == 5) ? a : b,
					($signed(a) > $signed(b) || phase == 5) ? b : a,
					32'($urandom_range(0, 32'h0100_0000)),
					32'(-signed'($urandom_range(0, 32'h0100_0000))), 2'(phase));
			calm = (phase == 3);
			if (phase == 2) begin
				// receiver holds off while requests keep coming
				hold_req++;
				random_run(100);
				// sender pauses until all results are back
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				random_run(100);
			end else begin
				random_run(200);
			end
			drain();
		end
		calm = 1'b0;

		if (fails == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+rtl
rtl/pidl_pkg.sv
rtl/pidl_if.sv
rtl/pid_controller_with_limits_core.sv
rtl/pidl_checker.sv
sim/pidl_checker.sv
sim/testbench.sv
